// ----- rtl/positional_insert_list_unit_assert.svh -----
// Assertion macros for the positional insert list unit.
`ifndef POSITIONAL_INSERT_LIST_UNIT_ASSERT_SVH
`define POSITIONAL_INSERT_LIST_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define PIL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define PIL_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define PIL_ASSERT(lbl, prop, msg)
`define PIL_NEVER(lbl, cond, msg)
`endif

`endif

// ----- rtl/pil_pkg.sv -----
package pil_pkg;

	localparam int LEN_W = 7;
	localparam int VAL_W = 32;

	localparam logic [1:0] STATUS_ENTRY   = 2'd0;
	localparam logic [1:0] STATUS_INVALID = 2'd1;
	localparam logic [1:0] STATUS_FULL    = 2'd2;

	typedef struct packed {
		logic                    ins;
		logic                    rot;
		logic [LEN_W-1:0]        pos;
		logic signed [VAL_W-1:0] value;
	} pil_ctrl_t;

endpackage

// ----- rtl/pil_cell.sv -----
module pil_cell
	import pil_pkg::*;
(
	input  logic                    clk,
	input  pil_ctrl_t               ctrl,
	input  logic [LEN_W-1:0]        cell_index,
	input  logic signed [VAL_W-1:0] shift_in,
	input  logic signed [VAL_W-1:0] rot_in,
	output logic signed [VAL_W-1:0] entry_value
);

	logic signed [VAL_W-1:0] entry_q;

	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (cell_index == ctrl.pos) begin
				entry_q <= ctrl.value;
			end else if (cell_index > ctrl.pos) begin
				entry_q <= shift_in;
			end
		end else if (ctrl.rot) begin
			entry_q <= rot_in;
		end
	end

	assign entry_value = entry_q;

endmodule

// ----- rtl/positional_insert_list_unit.sv -----
// Ordered list of up to CAPACITY signed 32-bit values held in a row of cells,
// one entry per cell, empty after reset. On an insert the cell at the position
// takes the new value and every cell past it takes its lower neighbor's value
// at once. With list_after set, the row then rotates a full turn toward cell 0,
// emitting one entry per cycle from cell 0 while the rotation covers the list
// and the output does not stall; no new insert is taken until the turn ends. An
// invalid position or a full list yields a single status result.
`include "positional_insert_list_unit_assert.svh"

module positional_insert_list_unit
	import pil_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [LEN_W-1:0]        insert_position,
	input  logic signed [VAL_W-1:0] new_value,
	input  logic                    list_after,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [1:0]              status,
	output logic signed [VAL_W-1:0] entry_value,
	output logic                    last_of_run
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_LIST = 1'b1;
	localparam logic [LEN_W-1:0] CAP_LEN  = LEN_W'(CAPACITY);
	localparam logic [LEN_W-1:0] CAP_LAST = LEN_W'(CAPACITY - 1);

	logic                    state_q;
	logic [LEN_W-1:0]        len_q;
	logic [LEN_W-1:0]        count_q;
	logic                    out_valid_q;
	logic [1:0]              status_q;
	logic signed [VAL_W-1:0] value_q;
	logic                    last_q;

	logic signed [VAL_W-1:0] cell_value [CAPACITY];
	pil_ctrl_t               ctrl;
	logic                    accept;
	logic                    pos_bad;
	logic                    list_full;
	logic                    slot_free;
	logic                    emit;
	logic                    step;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE) && slot_free;
	assign accept    = in_valid && in_ready;
	assign pos_bad   = insert_position > len_q;
	assign list_full = len_q == CAP_LEN;
	assign emit      = count_q < len_q;
	assign step      = (state_q == ST_LIST) && (!emit || slot_free);

	always_comb begin
		ctrl.ins   = accept && !pos_bad && !list_full;
		ctrl.rot   = step;
		ctrl.pos   = insert_position;
		ctrl.value = new_value;
	end

	genvar g;
	for (g = 0; g < CAPACITY; g++) begin : g_cell
		pil_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.cell_index (LEN_W'(g)),
			.shift_in   (cell_value[(g == 0) ? 0 : g - 1]),
			.rot_in     (cell_value[(g + 1) % CAPACITY]),
			.entry_value(cell_value[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			len_q       <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (pos_bad || list_full) begin
							out_valid_q <= 1'b1;
						end else begin
							len_q <= len_q + LEN_W'(1);
							if (list_after) begin
								state_q <= ST_LIST;
								count_q <= '0;
							end
						end
					end
				end
				ST_LIST: begin
					if (step) begin
						count_q <= count_q + LEN_W'(1);
						if (emit) begin
							out_valid_q <= 1'b1;
						end
						if (count_q == CAP_LAST) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= pos_bad ? STATUS_INVALID : STATUS_FULL;
			value_q  <= '0;
			last_q   <= 1'b1;
		end else if (step && emit) begin
			status_q <= STATUS_ENTRY;
			value_q  <= cell_value[0];
			last_q   <= count_q == (len_q - LEN_W'(1));
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign entry_value = value_q;
	assign last_of_run = last_q;

	`PIL_NEVER(a_len_cap, len_q > CAP_LEN, "list length beyond capacity")
	`PIL_ASSERT(a_len_grow, ctrl.ins |=> len_q == $past(len_q) + LEN_W'(1), "insert lost")
	`PIL_ASSERT(a_list_hold, state_q == ST_LIST |=> $stable(len_q), "length moved while listing")
	`PIL_NEVER(a_emit_past, step && emit && count_q >= len_q, "emit beyond list end")

endmodule
